>>> sv/switch_command_decoder_core_defines.svh
// assertion macros for the switch command decoder checker
// needs clk in the scope of each use, and rst for the two forms that are off during reset
`ifndef SWITCH_COMMAND_DECODER_CORE_DEFINES_SVH
`define SWITCH_COMMAND_DECODER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scd checker: property failed");

// next-cycle implication, off during reset
`define SCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scd checker: property failed");

// next-cycle implication that also covers reset
`define SCD_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scd checker: property failed");

`endif

>>> sv/scd_pkg.sv
// shared types and constants of the switch command decoder
// no dependencies
`default_nettype none

package scd_pkg;

  localparam int HOLD_COUNT_BITS_DEF = 16;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_THRESHOLD = 2'd1;

  localparam logic [15:0] HOLD_TICKS_RESET = 16'd3000;
  localparam logic [7:0] TIME_THRESHOLD_RESET = 8'd15;

  localparam logic [1:0] SW_UP = 2'd1;
  localparam logic [1:0] SW_MID = 2'd2;
  localparam logic [1:0] SW_DOWN = 2'd3;

  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_CANCEL = 4'd1;
  localparam logic [3:0] CMD_RECOVER = 4'd2;
  localparam logic [3:0] CMD_PREPARE = 4'd3;
  localparam logic [3:0] CMD_PREPARE_CANCEL = 4'd4;
  localparam logic [3:0] CMD_FIRE = 4'd5;
  localparam logic [3:0] CMD_ZERO_CAL = 4'd6;
  localparam logic [3:0] CMD_LEVEL = 4'd7;
  localparam logic [3:0] CMD_CARRIAGE_CAL = 4'd8;
  localparam logic [3:0] CMD_GAME_CONTROL = 4'd9;

  typedef struct packed {
    logic [1:0] left_switch;
    logic [1:0] right_switch;
    logic [1:0] knob_switch;
    logic       match_live;
    logic [7:0] time_left;
    logic [2:0] requests;
  } item_t;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [7:0]  time_threshold;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/scd_in_reg.sv
// input register stage: unpacks one tick from the slave stream
// depends on scd_pkg
`default_nettype none

module scd_in_reg
  import scd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_valid,
  output logic                      s_ready,
  input  wire logic [IN_DATA_W-1:0] s_data,
  input  wire logic                 advance,
  output logic                      item_valid,
  output item_t                     item
);

  assign s_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item.left_switch  <= s_data[1:0];
      item.right_switch <= s_data[3:2];
      item.knob_switch  <= s_data[5:4];
      item.match_live   <= s_data[6];
      item.time_left    <= s_data[14:7];
      item.requests     <= s_data[17:15];
    end
  end

endmodule

`default_nettype wire

>>> sv/scd_decide.sv
// decision logic and tick-to-tick state of the decoder
// depends on scd_pkg
`default_nettype none

module scd_decide
  import scd_pkg::*;
#(
  parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  advance,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output logic [3:0] command
);

  localparam int CMP_W = (HOLD_COUNT_BITS > 16) ? HOLD_COUNT_BITS : 16;

  logic [1:0] prev_left, prev_left_next;
  logic [1:0] prev_right, prev_right_next;
  logic       prepare_pending, prepare_pending_next;
  logic [2:0] pending_requests, pending_requests_next;
  logic       referee_was_true, referee_was_true_next;
  logic       hold_active, hold_active_next;
  logic [HOLD_COUNT_BITS-1:0] hold_count, hold_count_next;
  logic       hold_consumed, hold_consumed_next;

  logic [2:0] latched;
  logic       ref_cond;
  logic       knob_cond;
  logic       game_control;
  logic       left_mid;
  logic [HOLD_COUNT_BITS-1:0] count_inc;

  always_comb begin
    latched = pending_requests | item.requests;
    ref_cond = item.match_live && (item.time_left > cfg.time_threshold);
    knob_cond = (item.left_switch == SW_MID) && (item.right_switch == SW_MID) &&
                (item.knob_switch == SW_UP);
    left_mid = (item.left_switch == SW_MID);
    count_inc = (&hold_count) ? hold_count : hold_count + HOLD_COUNT_BITS'(1);

    prev_left_next = item.left_switch;
    prev_right_next = item.right_switch;
    prepare_pending_next = prepare_pending;
    pending_requests_next = latched;
    referee_was_true_next = ref_cond;
    hold_active_next = hold_active;
    hold_count_next = hold_count;
    hold_consumed_next = hold_consumed;
    game_control = 1'b0;
    command = CMD_NONE;

    // game control: referee edge first, then the knob hold
    if (ref_cond && !referee_was_true) begin
      game_control = 1'b1;
    end else if (!knob_cond) begin
      hold_active_next = 1'b0;
      hold_count_next = '0;
      hold_consumed_next = 1'b0;
    end else if (!hold_active) begin
      hold_active_next = 1'b1;
      hold_count_next = '0;
    end else begin
      hold_count_next = count_inc;
      if (!hold_consumed && (CMP_W'(count_inc) >= CMP_W'(cfg.hold_ticks))) begin
        hold_consumed_next = 1'b1;
        game_control = 1'b1;
      end
    end

    if (game_control) begin
      pending_requests_next = '0;
      command = CMD_GAME_CONTROL;
    end else if (item.left_switch == SW_UP) begin
      pending_requests_next = '0;
    end else if (!item.match_live && item.left_switch == SW_DOWN &&
                 item.right_switch == SW_DOWN) begin
      prepare_pending_next = 1'b0;
      pending_requests_next = '0;
      command = CMD_CANCEL;
    end else if (left_mid && prev_left == SW_DOWN) begin
      prepare_pending_next = 1'b0;
      pending_requests_next = '0;
      command = CMD_RECOVER;
    end else if (left_mid && prev_right == SW_MID && item.right_switch == SW_DOWN) begin
      pending_requests_next = '0;
      prepare_pending_next = !prepare_pending;
      command = prepare_pending ? CMD_PREPARE_CANCEL : CMD_PREPARE;
    end else if (left_mid && prev_right == SW_MID && item.right_switch == SW_UP) begin
      prepare_pending_next = 1'b0;
      pending_requests_next = '0;
      command = CMD_FIRE;
    end else if (latched[0]) begin
      pending_requests_next = latched & 3'b110;
      prepare_pending_next = 1'b0;
      command = CMD_ZERO_CAL;
    end else if (latched[1]) begin
      pending_requests_next = latched & 3'b101;
      prepare_pending_next = 1'b0;
      command = CMD_LEVEL;
    end else if (latched[2]) begin
      pending_requests_next = latched & 3'b011;
      prepare_pending_next = 1'b0;
      command = CMD_CARRIAGE_CAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left <= '0;
      prev_right <= '0;
      prepare_pending <= 1'b0;
      pending_requests <= '0;
      referee_was_true <= 1'b0;
      hold_active <= 1'b0;
      hold_count <= '0;
      hold_consumed <= 1'b0;
    end else if (advance) begin
      prev_left <= prev_left_next;
      prev_right <= prev_right_next;
      prepare_pending <= prepare_pending_next;
      pending_requests <= pending_requests_next;
      referee_was_true <= referee_was_true_next;
      hold_active <= hold_active_next;
      hold_count <= hold_count_next;
      hold_consumed <= hold_consumed_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/scd_out_reg.sv
// result register stage driving the master stream
// depends on scd_pkg
`default_nettype none

module scd_out_reg
  import scd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [3:0]            command,
  output logic                       out_free,
  output logic                       m_valid,
  input  wire logic                  m_ready,
  output logic [OUT_DATA_W-1:0]      m_data
);

  assign out_free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_data <= {{(OUT_DATA_W-4){1'b0}}, command};
    end
  end

endmodule

`default_nettype wire

>>> sv/switch_command_decoder_core.sv
// top level of the switch command decoder: config registers and stage wiring
// depends on scd_pkg, scd_in_reg, scd_decide, scd_out_reg
//
//  channel  | direction | signals                                   | payload
//  s_axis   | in        | s_axis_tvalid/tready/tdata[23:0]          | one tick
//  m_axis   | out       | m_axis_tvalid/tready/tdata[7:0]           | one command
//  cfg      | in        | cfg_valid/ready, cfg_index[1:0], cfg_data | register write
//
// each tick's command is registered, one tick per cycle while m_axis is ready
// the state update sits in one pass of logic between input and result registers
// a stalled master side holds the result and backs up into the input register
// rst is synchronous; config registers return to their defaults, cfg_ready is always high
`default_nettype none

module switch_command_decoder_core
  import scd_pkg::*;
#(
  parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // left_switch[1:0], right_switch[3:2], knob_switch[5:4], match_live[6],
  // time_left[14:7], req_zero_cal[15], req_level[16], req_carriage_cal[17]
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // command[3:0]
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  item_t      item;
  logic       item_valid;
  logic       out_free;
  logic       advance;
  logic [3:0] command;

  assign cfg_ready = 1'b1;
  assign advance = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks <= HOLD_TICKS_RESET;
      cfg.time_threshold <= TIME_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_TICKS:     cfg.hold_ticks <= cfg_data;
        REG_TIME_THRESHOLD: cfg.time_threshold <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  scd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_data     (s_axis_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  scd_decide #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_decide (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .command (command)
  );

  scd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .command  (command),
    .out_free (out_free),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> sv/scd_checker.sv
// port-level checks of the switch command decoder, bound to the top level
// depends on scd_pkg and switch_command_decoder_core_defines.svh
`default_nettype none
`include "switch_command_decoder_core_defines.svh"

module scd_checker
  import scd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  `SCD_ASSERT_ALWAYS_NEXT(a_reset_empties, rst, !m_axis_tvalid)
  `SCD_ASSERT_SAME(a_tick_gives_result, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid)
  `SCD_ASSERT_SAME(a_command_code, m_axis_tvalid, (m_axis_tdata <= OUT_DATA_W'(CMD_GAME_CONTROL)))
  `SCD_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind switch_command_decoder_core scd_checker u_scd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/tb.sv
// self-checking testbench for switch_command_decoder_core: directed table, then knob holds and random ticks
// commands are predicted in-bench or pinned by the directed table and compared in order; needs scd_pkg and the core rtl
`default_nettype none

module tb;
  import scd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 6;
  localparam int RESET_HOLD_ITEMS = 20;
  localparam int FAST_ITEMS = 40;
  localparam logic [15:0] FAST_HOLD = 16'd30;
  localparam logic [15:0] PHASE_HOLD [NUM_PHASES] =
    '{16'd1, 16'd2, 16'd7, 16'd40, 16'd3, 16'd12};
  localparam logic [7:0] PHASE_THRESHOLD [NUM_PHASES] =
    '{8'd0, 8'd255, 8'd15, 8'd128, 8'd1, 8'd200};
  localparam bit PINNED = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam logic [1:0] SW_UNKNOWN = 2'd0;

  typedef struct packed {
    logic [1:0] left_sw;
    logic [1:0] right_sw;
    logic [1:0] knob_sw;
    logic       started;
    logic [7:0] remaining;
    logic [2:0] reqs;  // bit0 zero cal, bit1 level, bit2 carriage cal
  } tick_t;

  typedef struct {
    tick_t      tick;
    bit         pinned;
    logic [3:0] cmd;
  } dir_row_t;

  typedef enum {TK_NOISE, TK_HOLD, TK_GESTURE, TK_REFEREE} tick_kind_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // decoder state as predicted
  logic [1:0]  dec_prev_left = SW_UNKNOWN;
  logic [1:0]  dec_prev_right = SW_UNKNOWN;
  logic        dec_armed = 1'b0;
  logic [2:0]  dec_pending = 3'd0;
  logic        dec_referee_seen = 1'b0;
  logic        dec_hold_on = 1'b0;
  logic [HOLD_COUNT_BITS_DEF-1:0] dec_hold_count = '0;
  logic        dec_hold_done = 1'b0;
  logic [15:0] hold_limit = HOLD_TICKS_RESET;
  logic [7:0]  threshold = TIME_THRESHOLD_RESET;

  logic [3:0] expected_cmds [$];
  dir_row_t directed_rows [$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_off_req = 1'b0;
  bit rx_fast = 1'b0;
  int stall_cycles = 0;

  switch_command_decoder_core uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [IN_DATA_W-1:0] pack_tick(input tick_t t);
    return {6'd0, t.reqs, t.remaining, t.started, t.knob_sw, t.right_sw, t.left_sw};
  endfunction

  // one tick of the decoder: updates the predicted state, returns the command
  function automatic logic [3:0] next_command(input tick_t t);
    logic referee_now;
    logic knob_now;
    logic fired;
    logic [3:0] cmd;
    dec_pending = dec_pending | t.reqs;
    referee_now = t.started && (t.remaining > threshold);
    fired = 1'b0;
    if (referee_now && !dec_referee_seen) begin
      dec_referee_seen = 1'b1;
      dec_pending = 3'd0;
      fired = 1'b1;
    end else begin
      dec_referee_seen = referee_now;
      knob_now = (t.left_sw == SW_MID) && (t.right_sw == SW_MID) && (t.knob_sw == SW_UP);
      if (!knob_now) begin
        dec_hold_on = 1'b0;
        dec_hold_count = '0;
        dec_hold_done = 1'b0;
      end else if (!dec_hold_on) begin
        dec_hold_on = 1'b1;
        dec_hold_count = '0;
      end else begin
        if (dec_hold_count != '1) dec_hold_count++;
        if (!dec_hold_done && dec_hold_count >= hold_limit) begin
          dec_hold_done = 1'b1;
          dec_pending = 3'd0;
          fired = 1'b1;
        end
      end
    end
    if (fired) begin
      cmd = CMD_GAME_CONTROL;
    end else if (t.left_sw == SW_UP) begin
      dec_pending = 3'd0;
      cmd = CMD_NONE;
    end else if (!t.started && t.left_sw == SW_DOWN && t.right_sw == SW_DOWN) begin
      dec_armed = 1'b0;
      dec_pending = 3'd0;
      cmd = CMD_CANCEL;
    end else if (t.left_sw == SW_MID && dec_prev_left == SW_DOWN) begin
      dec_armed = 1'b0;
      dec_pending = 3'd0;
      cmd = CMD_RECOVER;
    end else if (t.left_sw == SW_MID && dec_prev_right == SW_MID && t.right_sw == SW_DOWN) begin
      dec_pending = 3'd0;
      cmd = dec_armed ? CMD_PREPARE_CANCEL : CMD_PREPARE;
      dec_armed = !dec_armed;
    end else if (t.left_sw == SW_MID && dec_prev_right == SW_MID && t.right_sw == SW_UP) begin
      dec_armed = 1'b0;
      dec_pending = 3'd0;
      cmd = CMD_FIRE;
    end else if (dec_pending[0]) begin
      dec_pending[0] = 1'b0;
      dec_armed = 1'b0;
      cmd = CMD_ZERO_CAL;
    end else if (dec_pending[1]) begin
      dec_pending[1] = 1'b0;
      dec_armed = 1'b0;
      cmd = CMD_LEVEL;
    end else if (dec_pending[2]) begin
      dec_pending[2] = 1'b0;
      dec_armed = 1'b0;
      cmd = CMD_CARRIAGE_CAL;
    end else begin
      cmd = CMD_NONE;
    end
    dec_prev_left = t.left_sw;
    dec_prev_right = t.right_sw;
    return cmd;
  endfunction

  function automatic logic [2:0] rand_reqs();
    return {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
  endfunction

  function automatic tick_t make_tick(input tick_kind_t kind);
    tick_t t;
    int rt;
    t.left_sw = 2'($urandom_range(0, 3));
    t.right_sw = 2'($urandom_range(0, 3));
    t.knob_sw = 2'($urandom_range(0, 3));
    t.started = 1'($urandom_range(0, 1));
    t.remaining = 8'($urandom_range(0, 255));
    t.reqs = rand_reqs();
    case (kind)
      TK_NOISE: begin
        t.reqs = 3'($urandom_range(0, 7));
      end
      TK_HOLD: begin
        t.left_sw = SW_MID;
        t.right_sw = SW_MID;
        t.knob_sw = SW_UP;
        t.started = ($urandom_range(0, 15) == 0);
      end
      TK_GESTURE: begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3, 4: t.left_sw = SW_MID;
          5: t.left_sw = SW_DOWN;
          6: t.left_sw = SW_UP;
          default: t.left_sw = SW_UNKNOWN;
        endcase
        case ($urandom_range(0, 3))
          0: t.right_sw = SW_MID;
          1: t.right_sw = SW_DOWN;
          2: t.right_sw = SW_UP;
          default: t.right_sw = SW_UNKNOWN;
        endcase
      end
      default: begin
        t.started = ($urandom_range(0, 3) != 0);
        rt = int'(threshold) + $urandom_range(0, 2) - 1;
        if (rt < 0) rt = 0;
        if (rt > 255) rt = 255;
        t.remaining = 8'(rt);
      end
    endcase
    return t;
  endfunction

  function automatic void add_row(input logic [1:0] l, input logic [1:0] r,
                                  input logic [1:0] k, input logic gs,
                                  input logic [7:0] rt, input logic [2:0] reqs,
                                  input bit pinned, input logic [3:0] cmd);
    dir_row_t row;
    row.tick = '{left_sw: l, right_sw: r, knob_sw: k, started: gs, remaining: rt, reqs: reqs};
    row.pinned = pinned;
    row.cmd = cmd;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[tb] mismatch, %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_tick(input tick_t t, input bit pinned, input logic [3:0] pinned_cmd);
    int gap;
    logic [3:0] predicted;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_tick(t);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = next_command(t);
    expected_cmds.push_back(pinned ? pinned_cmd : predicted);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain_commands();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] ticks, input logic [7:0] thr);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HOLD_TICKS;
    cfg_data <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_TIME_THRESHOLD;
    cfg_data <= {8'($urandom_range(0, 255)), thr};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hold_limit = ticks;
    threshold = thr;
  endtask

  task automatic run_random(input int count);
    int n;
    int len;
    int i;
    tick_kind_t kind;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          kind = TK_NOISE;
          len = 1;
        end
        2, 3, 4: begin
          kind = TK_HOLD;
          len = $urandom_range(1, int'(hold_limit) + 3);
        end
        5, 6, 7: begin
          kind = TK_GESTURE;
          len = $urandom_range(2, 6);
        end
        default: begin
          kind = TK_REFEREE;
          len = $urandom_range(1, 4);
        end
      endcase
      for (i = 0; i < len; i++) send_tick(make_tick(kind), PREDICTED, CMD_NONE);
      n += len;
    end
  endtask

  // receiver: changing ready patterns, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int cyc;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        cyc++;
        if (rx_fast) begin
          m_axis_tready <= 1'b1;
        end else begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cyc % 7 != 3) && (cyc % 7 != 4);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [3:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("command with nothing outstanding", m_axis_tdata, 8'd0);
      end else begin
        want = expected_cmds.pop_front();
        if (m_axis_tdata !== {4'd0, want}) report_mismatch("command", m_axis_tdata, {4'd0, want});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[tb] no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[switch_command_decoder_core] ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    tick_t t;
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_NONE);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b111, PINNED, CMD_ZERO_CAL);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_LEVEL);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_CARRIAGE_CAL);
    // manual mode drops requests latched in the same tick
    add_row(SW_UP, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b111, PINNED, CMD_NONE);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_NONE);
    add_row(SW_DOWN, SW_DOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_CANCEL);
    add_row(SW_MID, SW_DOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_RECOVER);
    add_row(SW_MID, SW_MID, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_NONE);
    add_row(SW_MID, SW_DOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_PREPARE);
    add_row(SW_MID, SW_MID, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_NONE);
    add_row(SW_MID, SW_DOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_PREPARE_CANCEL);
    add_row(SW_MID, SW_MID, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_NONE);
    add_row(SW_MID, SW_DOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_PREPARE);
    // serving a request disarms the prepare
    add_row(SW_MID, SW_MID, SW_UNKNOWN, 1'b0, 8'd0, 3'b010, PINNED, CMD_LEVEL);
    add_row(SW_MID, SW_UP, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_FIRE);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b1, 8'd16, 3'b000, PINNED, CMD_GAME_CONTROL);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b1, 8'd255, 3'b000, PINNED, CMD_NONE);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b1, 8'd15, 3'b000, PINNED, CMD_NONE);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b1, 8'd16, 3'b001, PINNED, CMD_GAME_CONTROL);
    add_row(SW_UNKNOWN, SW_UNKNOWN, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PINNED, CMD_NONE);
    add_row(SW_DOWN, SW_DOWN, SW_DOWN, 1'b1, 8'd0, 3'b000, PREDICTED, CMD_NONE);
    add_row(SW_MID, SW_MID, SW_UP, 1'b0, 8'd255, 3'b000, PREDICTED, CMD_NONE);
    add_row(SW_MID, SW_MID, SW_UP, 1'b0, 8'd128, 3'b100, PREDICTED, CMD_NONE);
    add_row(SW_MID, SW_MID, SW_UNKNOWN, 1'b0, 8'd0, 3'b000, PREDICTED, CMD_NONE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].tick, directed_rows[i].pinned, directed_rows[i].cmd);
    end

    // knob hold against the reset value of hold_ticks
    for (i = 0; i < RESET_HOLD_ITEMS; i++) begin
      t = make_tick(TK_HOLD);
      t.started = 1'b0;
      send_tick(t, PREDICTED, CMD_NONE);
    end
    drain_commands();

    for (p = 0; p < NUM_PHASES; p++) begin
      program_regs(PHASE_HOLD[p], PHASE_THRESHOLD[p]);
      if (p == 1) hold_off_req = 1'b1;
      run_random(PHASE_ITEMS / 2);
      if (p == 3) drain_commands();
      run_random(PHASE_ITEMS / 2);
      drain_commands();
    end

    // back-to-back knob hold with the receiver always ready
    program_regs(FAST_HOLD, 8'hFF);
    gaps_on = 1'b0;
    rx_fast = 1'b1;
    for (i = 0; i < FAST_ITEMS; i++) send_tick(make_tick(TK_HOLD), PREDICTED, CMD_NONE);
    drain_commands();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[switch_command_decoder_core] OK");
    end else begin
      $display("[switch_command_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/scd_pkg.sv
sv/scd_in_reg.sv
sv/scd_decide.sv
sv/scd_out_reg.sv
sv/switch_command_decoder_core.sv
sv/scd_checker.sv
test/tb.sv
